[src/best_fit_hole_table_core_macros.svh]
// Assertion macros shared by the checker of the best-fit hole table core.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef BEST_FIT_HOLE_TABLE_CORE_MACROS_SVH
`define BEST_FIT_HOLE_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define BFHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define BFHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/bfht_pkg.sv]
// Shared types and constants of the best-fit hole table core.
// No dependencies; every other RTL file imports it.
`default_nettype none

package bfht_pkg;

    localparam int MAX_HOLES_DEF = 16;
    localparam int FIELD_W       = 31;
    localparam int COUNT_W       = 5;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_ALLOC  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_NOFIT = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INSERT,
        S_SEARCH
    } t_state;

    typedef struct packed {
        logic               cmd;
        logic [FIELD_W-1:0] hole_offset;
        logic [FIELD_W-1:0] hole_size;
        logic [FIELD_W-1:0] request_size;
    } t_cmd_in;

    typedef struct packed {
        logic [FIELD_W-1:0] alloc_offset;
        logic [1:0]         status;
        logic [COUNT_W-1:0] hole_count;
    } t_result;

    typedef struct packed {
        logic [FIELD_W-1:0] offset;
        logic [FIELD_W-1:0] size;
    } t_hole;

    // Per-cell shift control: take the left neighbor (insert) or the right one (removal).
    typedef struct packed {
        logic load_left;
        logic load_right;
    } t_cell_ctl;

endpackage

`default_nettype wire

[src/best_fit_hole_table_core.sv]
// Top level of the best-fit hole table core: control sequencer, row of cells, minimum tree.
// Depends on bfht_pkg, bfht_cell and bfht_min_tree.
//
// Usage. A command transfer happens at a rising edge where start is high and busy is low;
// i_item carries the command, the hole to insert and the requested size. Exactly one result
// follows on o_result, shown for a single cycle with o_strobe high. The receiver cannot hold
// a result off and the core never waits for it; busy is already low while the strobe is high.
//
// Sequence. After the accepting edge, an insert updates the table and registers the result,
// then shows it in the strobe cycle. An allocate registers the fit flags at the leaves, passes
// through each level of the registered minimum tree, removes the chosen entry and registers
// the result, then shows it in the strobe cycle. One command is in flight at a time, because
// each command changes the table that the next one searches; the next command can be taken at
// the edge that ends the strobe cycle, so the tree depth sets the allocate rate.
//
// The table is a row of cells. An insert shifts every cell one place back and loads the new
// hole into the first cell; a removal makes every cell at or behind the chosen one take its
// right neighbor. Reset clears the sequencer and the stored count only; cell contents are not
// cleared, and cells beyond the count are never chosen.
`default_nettype none

module best_fit_hole_table_core
    import bfht_pkg::*;
#(
    parameter int MAX_HOLES = MAX_HOLES_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire t_cmd_in i_item,
    output logic         o_strobe,
    output t_result      o_result
);

    localparam int IW     = $clog2(MAX_HOLES);
    localparam int CW     = $clog2(MAX_HOLES + 1);
    localparam int WAIT_W = $clog2(IW + 2);

    t_state           r_state,  n_state;
    logic [WAIT_W-1:0] r_wait,  n_wait;
    logic [CW-1:0]    r_count,  n_count;
    t_cmd_in          r_item,   n_item;
    t_result          r_result, n_result;
    logic             r_strobe, n_strobe;

    logic             do_insert;
    logic             do_remove;
    logic             table_full;

    t_hole            cell_hole [MAX_HOLES];
    t_cell_ctl        cell_ctl  [MAX_HOLES];
    logic [MAX_HOLES-1:0] cell_found;

    logic             best_found;
    logic [IW-1:0]    best_index;
    logic [FIELD_W-1:0] best_offset;

    assign table_full = (r_count == CW'(MAX_HOLES));
    assign busy       = (r_state != S_IDLE);

    // Row of cells. The first cell loads the held command's hole on an insert; the last
    // cell has no right neighbor and simply keeps its contents on a removal.
    for (genvar i = 0; i < MAX_HOLES; i++) begin : g_cell
        t_hole left_hole;
        t_hole right_hole;

        if (i == 0) begin : g_first
            assign left_hole = '{offset: r_item.hole_offset, size: r_item.hole_size};
        end else begin : g_mid
            assign left_hole = cell_hole[i-1];
        end

        if (i == MAX_HOLES - 1) begin : g_last
            assign right_hole = cell_hole[i];
        end else begin : g_inner
            assign right_hole = cell_hole[i+1];
        end

        assign cell_ctl[i].load_left  = do_insert;
        assign cell_ctl[i].load_right = do_remove && (IW'(i) >= best_index);

        // A cell is a candidate when it holds a stored hole that covers the request.
        assign cell_found[i] = (CW'(i) < r_count) &&
                               (cell_hole[i].size >= r_item.request_size);

        bfht_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[i]),
            .i_left  (left_hole),
            .i_right (right_hole),
            .o_hole  (cell_hole[i])
        );
    end

    bfht_min_tree #(
        .MAX_HOLES (MAX_HOLES)
    ) u_tree (
        .i_clk    (i_clk),
        .i_found  (cell_found),
        .i_hole   (cell_hole),
        .o_found  (best_found),
        .o_index  (best_index),
        .o_offset (best_offset)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wait   <= '0;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wait   <= n_wait;
            r_count  <= n_count;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item   <= n_item;
        r_result <= n_result;
    end

    always_comb begin
        n_state   = r_state;
        n_wait    = r_wait;
        n_count   = r_count;
        n_item    = r_item;
        n_result  = r_result;
        n_strobe  = 1'b0;
        do_insert = 1'b0;
        do_remove = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    if (i_item.cmd == CMD_ALLOC) begin
                        // Leaves, then every tree level, must settle on the new request.
                        n_wait  = WAIT_W'(IW + 1);
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_INSERT;
                    end
                end
            end
            S_INSERT: begin
                n_result.alloc_offset = '0;
                if (table_full) begin
                    n_result.status = ST_FULL;
                end else begin
                    do_insert       = 1'b1;
                    n_count         = r_count + CW'(1);
                    n_result.status = ST_DONE;
                end
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            S_SEARCH: begin
                if (r_wait != '0) begin
                    n_wait = r_wait - WAIT_W'(1);
                end else begin
                    if (best_found) begin
                        do_remove             = 1'b1;
                        n_count               = r_count - CW'(1);
                        n_result.alloc_offset = best_offset;
                        n_result.status       = ST_DONE;
                    end else begin
                        n_result.alloc_offset = '0;
                        n_result.status       = ST_NOFIT;
                    end
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The reported count is the count after this command, cut to the result field.
        n_result.hole_count = COUNT_W'(n_count);
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

[src/bfht_cell.sv]
// One entry of the hole table: a stored hole that shifts toward either neighbor.
// Depends on bfht_pkg.
`default_nettype none

module bfht_cell
    import bfht_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    input  wire t_hole     i_left,
    input  wire t_hole     i_right,
    output t_hole          o_hole
);

    t_hole r_hole;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_left) begin
            r_hole <= i_left;
        end else if (i_ctl.load_right) begin
            r_hole <= i_right;
        end
    end

    assign o_hole = r_hole;

endmodule

`default_nettype wire

[src/bfht_min_tree.sv]
// Registered minimum tree that picks the smallest fitting hole, earliest on a tie.
// Depends on bfht_pkg; one register level per tree level, leaves included.
`default_nettype none

module bfht_min_tree
    import bfht_pkg::*;
#(
    parameter int MAX_HOLES = MAX_HOLES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic [MAX_HOLES-1:0]         i_found,
    input  wire t_hole                        i_hole [MAX_HOLES],
    output logic                              o_found,
    output logic [$clog2(MAX_HOLES)-1:0]      o_index,
    output logic [FIELD_W-1:0]                o_offset
);

    localparam int IW = $clog2(MAX_HOLES);
    localparam int P  = 1 << IW;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] size;
        logic [FIELD_W-1:0] offset;
        logic [IW-1:0]      idx;
    } t_node;

    t_node r_node [2*P-1];

    // The right child wins only when it fits and is strictly smaller.
    function automatic t_node pick(input t_node lhs, input t_node rhs);
        if (rhs.found && (!lhs.found || (rhs.size < lhs.size))) begin
            return rhs;
        end
        return lhs;
    endfunction

    for (genvar k = 0; k < P; k++) begin : g_leaf
        if (k < MAX_HOLES) begin : g_used
            always_ff @(posedge i_clk) begin
                r_node[P-1+k] <= '{found: i_found[k], size: i_hole[k].size,
                                   offset: i_hole[k].offset, idx: IW'(k)};
            end
        end else begin : g_pad
            always_ff @(posedge i_clk) begin
                r_node[P-1+k] <= '{found: 1'b0, size: '0, offset: '0, idx: IW'(k)};
            end
        end
    end

    for (genvar k = 0; k < P-1; k++) begin : g_node
        always_ff @(posedge i_clk) begin
            r_node[k] <= pick(r_node[2*k+1], r_node[2*k+2]);
        end
    end

    assign o_found  = r_node[0].found;
    assign o_index  = r_node[0].idx;
    assign o_offset = r_node[0].offset;

endmodule

`default_nettype wire

[src/bfht_checker.sv]
// Port-level checker for the best-fit hole table core, bound to the top level.
// Depends on bfht_pkg and best_fit_hole_table_core_macros.svh.
`default_nettype none

`include "best_fit_hole_table_core_macros.svh"

module bfht_checker
    import bfht_pkg::*;
#(
    parameter int MAX_HOLES = MAX_HOLES_DEF
) (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    o_strobe,
    input wire t_result o_result
);

    // An accepted command keeps the core busy in the following cycle.
    `BFHT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // A dropped insert is only reported when the table holds its full count.
    `BFHT_ASSERT_NOW(a_full_count, o_strobe && (o_result.status == ST_FULL),
        o_result.hole_count == COUNT_W'(MAX_HOLES))

    // A failed allocation returns a zero offset.
    `BFHT_ASSERT_NOW(a_nofit_zero, o_strobe && (o_result.status == ST_NOFIT),
        o_result.alloc_offset == '0)

    // Each command gives one result, so the strobe never stays high across a clock edge.
    `BFHT_ASSERT_NEXT(a_single_strobe, o_strobe, !o_strobe)

endmodule

bind best_fit_hole_table_core bfht_checker #(
    .MAX_HOLES (MAX_HOLES)
) u_bfht_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire
